### design/lzssw_pkg.sv
// ----------------------------------------------------------------------------
// lzssw_pkg
// Shared widths, token field masks, register map and the output item type of
// the windowed LZSS decompressor.
// ----------------------------------------------------------------------------
package lzssw_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 24;
  localparam int LEN_W    = 5;
  localparam int SUM_W    = 13;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int MIN_MATCH     = 3;
  localparam int POSITION_BIAS = 18;
  localparam int MAX_RESULTS   = 18;

  localparam logic [BYTE_W-1:0]  LEN_MASK    = 8'h0F;
  localparam logic [BYTE_W-1:0]  POS_MASK    = 8'hF0;
  localparam logic [BYTE_W-1:0]  LIT_MASK    = 8'h01;
  localparam logic [3:0]         FLAG_COUNT  = 4'd8;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 24'hFFFFFF;

  // word index of the output limit register
  localparam logic REG_LIMIT = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              lim;
  } out_item_t;

endpackage

### design/lzss_window_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lzss_window_decompressor_unit
// Streaming LZSS decoder: flag bytes, literals and two-byte matches copied
// out of a history ring held in a simple dual-port synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | compressed byte, end of stream in tlast
//  m_*      | out       | decompressed byte, last of transfer group in tlast,
//           |           | limit hit in tuser
//  apb      | in        | output limit register at byte address 0
//
//  flag, literal and match-low bytes are taken while idle with a free
//  output slot; a match first reduces its start slot into the window,
//  then copies each byte as a ring read followed by emit and write
//  back
//  reset clears control state; the ring needs no clearing pass since reads
//  before the stream start are forced to zero
//  a stalled output holds the next byte; input waits while a copy runs
// ----------------------------------------------------------------------------
module lzss_window_decompressor_unit #(
  parameter int WINDOW_SIZE = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lzssw_pkg::BYTE_W-1:0]      s_tdata,   // compressed_byte
  input  logic                              s_tlast,   // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lzssw_pkg::BYTE_W-1:0]      m_tdata,   // out_byte
  output logic                              m_tlast,   // run_last
  output logic                              m_tuser,   // limit_reached
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lzssw_pkg::PADDR_W-1:0]     paddr,
  input  logic [lzssw_pkg::PDATA_W-1:0]     pwdata,
  output logic [lzssw_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int DW = AW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [lzssw_pkg::BYTE_W-1:0] ring [WINDOW_SIZE];
  logic [lzssw_pkg::BYTE_W-1:0] rdata;

  logic [1:0]                    state;
  logic [lzssw_pkg::COUNT_W-1:0] cnt;
  logic [lzssw_pkg::COUNT_W-1:0] limit;
  logic [AW-1:0]                 wptr;
  logic [lzssw_pkg::BYTE_W-1:0]  flags;
  logic [3:0]                    left;
  logic                          phase;
  logic [lzssw_pkg::BYTE_W-1:0]  low;
  logic                          stopped;
  logic [lzssw_pkg::SUM_W-1:0]   src;
  logic [lzssw_pkg::LEN_W-1:0]   rem;
  logic                          pend_last;
  lzssw_pkg::out_item_t          out_item;
  logic                          out_valid;

  logic                          accept;
  logic                          slot_free;
  logic                          stop_eff;
  logic                          is_literal;
  logic                          lit_emit;
  logic                          copy_emit;
  logic                          we;
  logic [lzssw_pkg::BYTE_W-1:0]  wdata;
  logic [lzssw_pkg::COUNT_W-1:0] cnt_inc;
  logic                          hit;
  logic [AW-1:0]                 wptr_inc;
  logic [DW-1:0]                 diff;
  logic [DW-1:0]                 back_dist;
  logic [lzssw_pkg::BYTE_W-1:0]  copy_byte;
  logic [lzssw_pkg::LEN_W-1:0]   len_raw;
  logic [lzssw_pkg::LEN_W-1:0]   len;
  logic [lzssw_pkg::SUM_W-1:0]   src_start;
  logic [lzssw_pkg::SUM_W-1:0]   src_inc;
  logic                          copy_done;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == lzssw_pkg::REG_LIMIT) ?
                     {{(lzssw_pkg::PDATA_W-lzssw_pkg::COUNT_W){1'b0}}, limit} : '0;

  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;
  assign stop_eff  = stopped || (cnt >= limit);

  assign is_literal = (flags & lzssw_pkg::LIT_MASK) != '0;
  assign lit_emit   = accept && !stop_eff && !phase && (left != 4'd0) && is_literal;
  assign copy_emit  = (state == ST_EMIT) && slot_free;

  assign cnt_inc  = cnt + lzssw_pkg::COUNT_W'(1);
  assign hit      = cnt_inc >= limit;
  assign wptr_inc = (wptr == AW'(WINDOW_SIZE - 1)) ? '0 : wptr + AW'(1);

  // distance back from the write slot to the copy source
  assign diff = ({1'b0, src[AW-1:0]} >= {1'b0, wptr}) ?
                {1'b0, src[AW-1:0]} - {1'b0, wptr} :
                {1'b0, src[AW-1:0]} + DW'(WINDOW_SIZE) - {1'b0, wptr};
  assign back_dist = DW'(WINDOW_SIZE) - diff;
  assign copy_byte = (lzssw_pkg::COUNT_W'(back_dist) <= cnt) ? rdata : '0;

  assign len_raw   = lzssw_pkg::LEN_W'(s_tdata & lzssw_pkg::LEN_MASK)
                   + lzssw_pkg::LEN_W'(lzssw_pkg::MIN_MATCH);
  assign len       = (len_raw > lzssw_pkg::LEN_W'(lzssw_pkg::MAX_RESULTS)) ?
                     lzssw_pkg::LEN_W'(lzssw_pkg::MAX_RESULTS) : len_raw;
  assign src_start = {1'b0, s_tdata[7:4], low}
                   + lzssw_pkg::SUM_W'(lzssw_pkg::POSITION_BIAS);
  assign src_inc   = (src[AW-1:0] == AW'(WINDOW_SIZE - 1)) ? '0 :
                     src + lzssw_pkg::SUM_W'(1);
  assign copy_done = hit || (rem == lzssw_pkg::LEN_W'(1));

  assign we    = lit_emit || copy_emit;
  assign wdata = lit_emit ? s_tdata : copy_byte;

  // history ring
  always_ff @(posedge clk) begin
    if (we) begin
      ring[wptr] <= wdata;
    end
    rdata <= ring[src[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lit_emit) begin
      out_item.data <= s_tdata;
      out_item.last <= 1'b1;
      out_item.lim  <= hit;
    end else if (copy_emit) begin
      out_item.data <= copy_byte;
      out_item.last <= copy_done;
      out_item.lim  <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= we || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= lzssw_pkg::LIMIT_RESET;
    end else if (cfg_write && (paddr[2] == lzssw_pkg::REG_LIMIT)) begin
      limit <= pwdata[lzssw_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      wptr      <= '0;
      flags     <= '0;
      left      <= '0;
      phase     <= 1'b0;
      low       <= '0;
      stopped   <= 1'b0;
      src       <= '0;
      rem       <= '0;
      pend_last <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            stopped <= stop_eff;
            if (!stop_eff) begin
              if (phase) begin
                phase     <= 1'b0;
                src       <= src_start;
                rem       <= len;
                pend_last <= s_tlast;
                state     <= ST_REDUCE;
              end else if (left == 4'd0) begin
                flags <= s_tdata;
                left  <= lzssw_pkg::FLAG_COUNT;
              end else begin
                flags <= flags >> 1;
                left  <= left - 4'd1;
                if (is_literal) begin
                  cnt  <= cnt_inc;
                  wptr <= wptr_inc;
                  if (hit) begin
                    stopped <= 1'b1;
                  end
                end else begin
                  low   <= s_tdata;
                  phase <= 1'b1;
                end
              end
            end
            if (s_tlast && (stop_eff || !phase)) begin
              cnt     <= '0;
              wptr    <= '0;
              flags   <= '0;
              left    <= '0;
              phase   <= 1'b0;
              low     <= '0;
              stopped <= 1'b0;
            end
          end
        end
        ST_REDUCE: begin
          if (src >= lzssw_pkg::SUM_W'(WINDOW_SIZE)) begin
            src <= src - lzssw_pkg::SUM_W'(WINDOW_SIZE);
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            cnt  <= cnt_inc;
            wptr <= wptr_inc;
            src  <= src_inc;
            rem  <= rem - lzssw_pkg::LEN_W'(1);
            if (hit) begin
              stopped <= 1'b1;
            end
            if (copy_done) begin
              state <= ST_IDLE;
              if (pend_last) begin
                cnt       <= '0;
                wptr      <= '0;
                flags     <= '0;
                left      <= '0;
                phase     <= 1'b0;
                low       <= '0;
                stopped   <= 1'b0;
                pend_last <= 1'b0;
              end
            end else begin
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_item.data;
  assign m_tlast  = out_item.last;
  assign m_tuser  = out_item.lim;

  a_no_input_during_copy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input taken while a match copy runs");

  a_wptr_in_window: assert property (@(posedge clk) disable iff (rst)
    wptr <= AW'(WINDOW_SIZE - 1))
    else $error("write slot outside the window");

  a_src_reduced: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_READ) || (state == ST_EMIT)) |->
      (src < lzssw_pkg::SUM_W'(WINDOW_SIZE)))
    else $error("copy source not reduced into the window");

  a_copy_end_marked: assert property (@(posedge clk) disable iff (rst)
    (copy_emit && (rem == lzssw_pkg::LEN_W'(1))) |=> (m_tvalid && m_tlast))
    else $error("final copied byte not marked last");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rem != '0))
    else $error("copy running with no bytes left");

endmodule

### dv/lzssw_stream_checker.sv
// ----------------------------------------------------------------------------
// lzssw_stream_checker
// Watches the compressed input, decompressed output and register channels of
// the windowed LZSS decompressor. It keeps its own copy of the decoder state,
// works out the bytes each accepted input transfer should produce and compares
// every output transfer field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lzssw_stream_checker #(
  parameter int WINDOW_SIZE = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [lzssw_pkg::BYTE_W-1:0]  s_tdata,   // compressed_byte
  input  logic                          s_tlast,   // last_byte
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [lzssw_pkg::BYTE_W-1:0]  m_tdata,   // out_byte
  input  logic                          m_tlast,   // run_last
  input  logic                          m_tuser,   // limit_reached
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lzssw_pkg::PADDR_W-1:0] paddr,
  input  logic [lzssw_pkg::PDATA_W-1:0] pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending
);

  logic [lzssw_pkg::BYTE_W-1:0]  history [WINDOW_SIZE];
  logic [lzssw_pkg::COUNT_W-1:0] produced;
  logic [lzssw_pkg::COUNT_W-1:0] out_limit;
  logic [lzssw_pkg::BYTE_W-1:0]  flags;
  logic [3:0]                    flags_left;
  logic [lzssw_pkg::BYTE_W-1:0]  match_low;
  logic                          awaiting_high;
  logic                          halted;
  lzssw_pkg::out_item_t          owed_bytes[$];

  function automatic void restart_stream();
    produced      = '0;
    flags         = '0;
    flags_left    = '0;
    match_low     = '0;
    awaiting_high = 1'b0;
    halted        = 1'b0;
  endfunction

  function automatic void emit_byte(input logic [lzssw_pkg::BYTE_W-1:0] v);
    lzssw_pkg::out_item_t item;
    history[produced % WINDOW_SIZE] = v;
    produced  = produced + 1'b1;
    item.data = v;
    item.last = 1'b0;
    item.lim  = (produced >= out_limit);
    if (item.lim) halted = 1'b1;
    owed_bytes.push_back(item);
  endfunction

  function automatic void decode_in_byte(input logic [lzssw_pkg::BYTE_W-1:0] b,
                                         input logic lst);
    int unsigned pos;
    int unsigned len;
    int unsigned src;
    int unsigned diff;
    int unsigned back_dist;
    int unsigned start_size;
    logic [lzssw_pkg::BYTE_W-1:0] v;
    lzssw_pkg::out_item_t tail;
    start_size = owed_bytes.size();
    if (!halted && produced >= out_limit) halted = 1'b1;
    if (!halted) begin
      if (awaiting_high) begin
        pos = {b & lzssw_pkg::POS_MASK, 4'h0} | match_low;
        len = (b & lzssw_pkg::LEN_MASK) + lzssw_pkg::MIN_MATCH;
        awaiting_high = 1'b0;
        if (len > lzssw_pkg::MAX_RESULTS) len = lzssw_pkg::MAX_RESULTS;
        src = (pos + lzssw_pkg::POSITION_BIAS) % WINDOW_SIZE;
        for (int i = 0; i < len && !halted; i++) begin
          diff = (src + WINDOW_SIZE - (produced % WINDOW_SIZE)) % WINDOW_SIZE;
          back_dist = WINDOW_SIZE - diff;
          v = (back_dist <= produced) ?
              history[(produced - back_dist) % WINDOW_SIZE] : '0;
          emit_byte(v);
          src = (src + 1) % WINDOW_SIZE;
        end
      end else if (flags_left == 0) begin
        flags      = b;
        flags_left = lzssw_pkg::FLAG_COUNT;
      end else begin
        flags_left = flags_left - 1'b1;
        if ((flags & lzssw_pkg::LIT_MASK) != 0) begin
          flags = flags >> 1;
          emit_byte(b);
        end else begin
          flags         = flags >> 1;
          match_low     = b;
          awaiting_high = 1'b1;
        end
      end
    end
    if (owed_bytes.size() > start_size) begin
      tail = owed_bytes.pop_back();
      tail.last = 1'b1;
      owed_bytes.push_back(tail);
    end
    if (lst) restart_stream();
  endfunction

  always @(posedge clk) begin
    lzssw_pkg::out_item_t got;
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) history[i] = '0;
      out_limit = lzssw_pkg::LIMIT_RESET;
      restart_stream();
      owed_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[lzssw_pkg::PADDR_W-1:2] == lzssw_pkg::REG_LIMIT &&
          paddr[1:0] == 2'b00) begin
        out_limit = pwdata[lzssw_pkg::COUNT_W-1:0];
      end
      if (s_tvalid && s_tready) decode_in_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (owed_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %h", m_tdata);
          errors = errors + 1;
        end else begin
          got = owed_bytes.pop_front();
          if (got.data !== m_tdata) begin
            $error("out_byte: expected %h, actual %h", got.data, m_tdata);
            errors = errors + 1;
          end
          if (got.last !== m_tlast) begin
            $error("run_last: expected %b, actual %b", got.last, m_tlast);
            errors = errors + 1;
          end
          if (got.lim !== m_tuser) begin
            $error("limit_reached: expected %b, actual %b", got.lim, m_tuser);
            errors = errors + 1;
          end
        end
      end
    end
    pending = owed_bytes.size();
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the windowed LZSS decompressor with directed token streams for the
// literal extremes, overlapping and pre-stream copies, dropped partial tokens
// and the output limit, then with random well-formed, truncated and noise
// streams under several settings of the limit and of source and sink idling.
// Checking is done by the stream checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lzssw_pkg::BYTE_W-1:0]  s_tdata  = '0;   // compressed_byte
  logic                          s_tlast  = 1'b0; // last_byte
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lzssw_pkg::BYTE_W-1:0]  m_tdata;         // out_byte
  logic                          m_tlast;         // run_last
  logic                          m_tuser;         // limit_reached
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [lzssw_pkg::PADDR_W-1:0] paddr    = '0;
  logic [lzssw_pkg::PDATA_W-1:0] pwdata   = '0;
  logic [lzssw_pkg::PDATA_W-1:0] prdata;
  logic                          pready;

  int                            mismatches;
  int                            owed;
  int                            src_idle_pct  = 0;
  int                            sink_stall_pct = 0;
  logic [lzssw_pkg::BYTE_W-1:0]  tx_bytes[$];

  always #5 clk = ~clk;

  lzss_window_decompressor_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  lzssw_stream_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .errors(mismatches), .pending(owed)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_byte(input logic [lzssw_pkg::BYTE_W-1:0] d, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the source off until every owed byte has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_stream(input bit close, input bit may_pause);
    for (int i = 0; i < tx_bytes.size(); i++) begin
      if (may_pause && i > 0 && $urandom_range(59) == 0) wait_idle();
      send_byte(tx_bytes[i], close && (i == tx_bytes.size() - 1));
    end
  endtask

  task automatic apb_write(input logic [lzssw_pkg::PADDR_W-1:0] a,
                           input logic [lzssw_pkg::PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int        sent;
    int        kind;
    int        ntok;
    int        est;
    int        src;
    int        pos;
    int        nib;
    int        cut;
    logic [7:0] fl;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // literal extremes, overlapping copy, copy from before stream start,
    // partial token dropped at stream end
    tx_bytes = '{8'h03, 8'h00, 8'hFF, 8'hEE, 8'hF0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h5A};
    send_stream(1, 0);
    wait_idle();

    // limit cuts a long match, later input ignored
    apb_write(3'd0, 32'd5);
    tx_bytes = '{8'h01, 8'h11, 8'hEE, 8'hFF, 8'h77, 8'h88};
    send_stream(1, 0);
    wait_idle();

    // limit zero: nothing produced
    apb_write(3'd0, 32'd0);
    tx_bytes = '{8'hFF, 8'h22, 8'h33};
    send_stream(1, 0);
    wait_idle();

    // limit lowered below the count in mid stream
    apb_write(3'd0, 32'd8);
    tx_bytes = '{8'hFF, 8'h41, 8'h42, 8'h43};
    send_stream(0, 0);
    wait_idle();
    apb_write(3'd0, 32'd2);
    tx_bytes = '{8'h44, 8'h45};
    send_stream(1, 0);
    wait_idle();

    // a write to an unmapped register leaves the limit alone
    apb_write(3'd4, $urandom);

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          src_idle_pct = 0;  sink_stall_pct = 0;
          apb_write(3'd0, {8'h00, lzssw_pkg::LIMIT_RESET});
        end
        1: begin
          src_idle_pct = 51; sink_stall_pct = 0;
          apb_write(3'd0, $urandom_range(1, 40));
        end
        2: begin
          src_idle_pct = 0;  sink_stall_pct = 51;
          apb_write(3'd0, $urandom);
        end
        default: begin
          src_idle_pct = 19; sink_stall_pct = 19;
          apb_write(3'd0, $urandom_range(20, 150));
        end
      endcase
      sent = 0;
      while (sent < 86) begin
        tx_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
          repeat ($urandom_range(1, 16)) tx_bytes.push_back(8'($urandom));
        end else begin
          ntok = $urandom_range(2, 28);
          est  = 0;
          while (ntok > 0) begin
            fl = 8'($urandom);
            tx_bytes.push_back(fl);
            for (int b = 0; b < 8 && ntok > 0; b++) begin
              ntok--;
              if (fl[b]) begin
                tx_bytes.push_back(8'($urandom));
                est++;
              end else begin
                nib = ($urandom_range(3) == 0) ? 15 : $urandom_range(15);
                // mostly point back into bytes already produced
                if (est > 0 && $urandom_range(3) != 0)
                  src = (est - $urandom_range(1, est)) % 4096;
                else
                  src = $urandom_range(4095);
                pos = (src + 4096 - lzssw_pkg::POSITION_BIAS) % 4096;
                tx_bytes.push_back(pos[7:0]);
                tx_bytes.push_back({pos[11:8], nib[3:0]});
                est += nib + lzssw_pkg::MIN_MATCH;
              end
            end
          end
          if (kind >= 90) begin
            cut = $urandom_range(1, tx_bytes.size());
            while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
          end
        end
        send_stream(1, 1);
        sent += tx_bytes.size();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
